>>> design/lcfb_pkg.sv
// ----------------------------------------------------------------------------
// LCD command frame builder package
// Shared constants, request codes and the frame descriptor type.
// ----------------------------------------------------------------------------
package lcfb_pkg;

    localparam logic [7:0] FRAME_HEAD  = 8'hC5;
    localparam logic [7:0] CMD_ONOFF   = 8'h01;
    localparam logic [7:0] CMD_DIGITS  = 8'h02;
    localparam logic [7:0] CMD_SEGS    = 8'h03;
    localparam logic [7:0] DIGIT_BLANK = 8'h10;
    localparam logic [7:0] DIGIT_ONE   = 8'h01;
    localparam logic [7:0] BAR_FULL    = 8'hFF;
    localparam logic [7:0] PCT_BIT     = 8'h20;
    localparam logic [7:0] OUTLINE_BIT = 8'h40;
    localparam int         BAR_STEP    = 13;
    localparam int         BAR_COUNT   = 7;
    localparam logic [6:0] VALUE_MAX   = 7'd100;
    // Reciprocal of ten scaled by 2^11, exact for the values in use.
    localparam logic [7:0] RECIP_TEN   = 8'd205;
    localparam int         RECIP_SHIFT = 11;

    localparam int         BODY_LEN    = 5;
    localparam logic [2:0] LAST_SHORT  = 3'd3;
    localparam logic [2:0] LAST_LONG   = 3'd5;

    localparam int         QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        REQ_ON    = 2'd0,
        REQ_OFF   = 2'd1,
        REQ_DIGIT = 2'd2,
        REQ_BAR   = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]                 channel;
        logic                       long_frame;
        logic [BODY_LEN-1:0][7:0]   body;
    } t_frame;

endpackage

>>> design/lcfb_front.sv
// ----------------------------------------------------------------------------
// LCD command frame builder front end
// Accepts requests, builds the frame body and checksum, and holds it for the
// queue.
// ----------------------------------------------------------------------------
module lcfb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_req_type,
    input  logic [1:0]           i_channel,
    input  logic [6:0]           i_value,
    output logic                 o_push,
    output lcfb_pkg::t_frame     o_frame,
    input  logic                 i_full
);

    logic             r_valid;
    lcfb_pkg::t_frame r_frame;
    lcfb_pkg::t_frame n_frame;

    logic [6:0]  v_sat;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  units;
    logic [7:0]  bar;
    logic [7:0]  rev;
    logic [7:0]  seg_a;
    logic [7:0]  seg_b;
    logic [7:0]  onoff;
    logic        accept;

    function automatic logic req_is_on(input logic [1:0] req);
        return lcfb_pkg::t_req'(req) == lcfb_pkg::REQ_ON;
    endfunction

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_frame = r_frame;

    always_comb begin
        v_sat = (i_value > lcfb_pkg::VALUE_MAX) ? lcfb_pkg::VALUE_MAX : i_value;
        prod  = 15'(v_sat) * 15'(lcfb_pkg::RECIP_TEN);
        tens  = prod[14:lcfb_pkg::RECIP_SHIFT];
        units = 4'(v_sat - 7'(tens) * 7'd10);

        bar = lcfb_pkg::BAR_FULL;
        for (int k = 1; k <= lcfb_pkg::BAR_COUNT; k++) begin
            if (i_value < 7'(lcfb_pkg::BAR_STEP * k)) begin
                bar = {bar[6:0], 1'b0};
            end
        end
        for (int i = 0; i < 8; i++) begin
            rev[i] = bar[7-i];
        end
        seg_a = lcfb_pkg::PCT_BIT | {bar[6], bar[7], 6'd0};
        seg_b = (rev >> 2) | lcfb_pkg::OUTLINE_BIT;
        onoff = (req_is_on(i_req_type)) ? 8'h01 : 8'h00;

        n_frame         = '0;
        n_frame.channel = i_channel;
        unique case (lcfb_pkg::t_req'(i_req_type))
            lcfb_pkg::REQ_ON, lcfb_pkg::REQ_OFF: begin
                n_frame.long_frame = 1'b0;
                n_frame.body[0]    = lcfb_pkg::CMD_ONOFF;
                n_frame.body[1]    = onoff;
                n_frame.body[2]    = lcfb_pkg::CMD_ONOFF + onoff;
            end
            lcfb_pkg::REQ_DIGIT: begin
                n_frame.long_frame = 1'b1;
                n_frame.body[0]    = lcfb_pkg::CMD_DIGITS;
                n_frame.body[1]    = (v_sat == lcfb_pkg::VALUE_MAX) ?
                                     lcfb_pkg::DIGIT_ONE : lcfb_pkg::DIGIT_BLANK;
                // At full scale the tens digit wraps to zero.
                n_frame.body[2]    = {4'd0, (tens == 4'd10) ? 4'd0 : tens};
                n_frame.body[3]    = {4'd0, units};
                n_frame.body[4]    = n_frame.body[0] + n_frame.body[1]
                                   + n_frame.body[2] + n_frame.body[3];
            end
            lcfb_pkg::REQ_BAR: begin
                n_frame.long_frame = 1'b1;
                n_frame.body[0]    = lcfb_pkg::CMD_SEGS;
                n_frame.body[1]    = seg_a;
                n_frame.body[2]    = seg_b;
                n_frame.body[3]    = 8'h00;
                n_frame.body[4]    = lcfb_pkg::CMD_SEGS + seg_a + seg_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_frame <= n_frame;
        end
    end

endmodule

>>> design/lcfb_queue.sv
// ----------------------------------------------------------------------------
// LCD command frame builder queue
// Short first-in first-out queue of frame descriptors between front and back.
// ----------------------------------------------------------------------------
module lcfb_queue #(
    parameter int QUEUE_DEPTH = lcfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lcfb_pkg::t_frame     i_frame,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output lcfb_pkg::t_frame     o_frame
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

    lcfb_pkg::t_frame r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

>>> design/lcfb_back.sv
// ----------------------------------------------------------------------------
// LCD command frame builder back end
// Takes frame descriptors from the queue and sends them out one byte per beat
// through an output register.
// ----------------------------------------------------------------------------
module lcfb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  lcfb_pkg::t_frame     i_q_frame,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_out_channel,
    output logic [7:0]           o_frame_byte,
    output logic                 o_last_byte
);

    lcfb_pkg::t_frame r_cur;
    logic             r_act;
    logic [2:0]       r_idx;
    logic             r_out_valid;
    logic [1:0]       r_out_channel;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             adv;
    logic             load_out;
    logic             cur_last;
    logic [2:0]       body_idx;
    logic [7:0]       cur_byte;

    always_comb begin
        adv      = !r_out_valid || !i_stall;
        load_out = adv && r_act;
        cur_last = (r_idx == (r_cur.long_frame ? lcfb_pkg::LAST_LONG
                                               : lcfb_pkg::LAST_SHORT));
        o_pop    = i_q_valid && (!r_act || (load_out && cur_last));
        body_idx = r_idx - 3'd1;
        if (r_idx == 3'd0) begin
            cur_byte = lcfb_pkg::FRAME_HEAD;
        end else if (body_idx < 3'(lcfb_pkg::BODY_LEN)) begin
            cur_byte = r_cur.body[body_idx];
        end else begin
            cur_byte = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (load_out) begin
                r_idx <= r_idx + 3'd1;
                if (cur_last) begin
                    r_act <= 1'b0;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (adv) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_frame;
        end
        if (load_out) begin
            r_out_channel <= r_cur.channel;
            r_out_byte    <= cur_byte;
            r_out_last    <= cur_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_frame_byte  = r_out_byte;
    assign o_last_byte   = r_out_last;

endmodule

>>> design/lcd_command_frame_builder_core.sv
// A request passes the front register, queue, back-end frame and output registers.
// Throughput: one beat per cycle while the receiver does not stall; on/off frames are four
// bytes long and number or level-bar frames six, as the back end sends one byte per cycle.
// The front end takes a new request every cycle while the queue has room.
// Reset is synchronous and active low; it empties the front register, the
// queue and the output register. There is no clearing pass.
// ----------------------------------------------------------------------------
// LCD command frame builder core
// Turns display requests into serial command frames, one byte per beat.
// ----------------------------------------------------------------------------
module lcd_command_frame_builder_core #(
    parameter int QUEUE_DEPTH = lcfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_channel,
    input  logic [6:0]  i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_channel,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);

    logic             push;
    logic             full;
    logic             pop;
    logic             q_valid;
    lcfb_pkg::t_frame front_frame;
    lcfb_pkg::t_frame q_frame;

    lcfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_channel  (i_channel),
        .i_value    (i_value),
        .o_push     (push),
        .o_frame    (front_frame),
        .i_full     (full)
    );

    lcfb_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_frame (q_frame)
    );

    lcfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_frame     (q_frame),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_frame_byte  (o_frame_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

>>> design/lcfb_checker.sv
// ----------------------------------------------------------------------------
// LCD command frame builder checker
// Port-level assertions on the output beat stream, bound to the core.
// ----------------------------------------------------------------------------
module lcfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_out_channel,
    input logic [7:0]  o_frame_byte,
    input logic        o_last_byte
);

    // A stalled beat stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_byte)
                               && $stable(o_out_channel) && $stable(o_last_byte))
        else $error("stalled beat changed");

    // The output is empty after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // The bytes of one frame follow each other without a gap.
    a_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_byte |=> o_valid)
        else $error("gap inside a frame");

    // All bytes of one frame go to the same display.
    a_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_byte |=> o_out_channel == $past(o_out_channel))
        else $error("channel changed inside a frame");

endmodule

bind lcd_command_frame_builder_core lcfb_checker u_lcfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_channel (o_out_channel),
    .o_frame_byte  (o_frame_byte),
    .o_last_byte   (o_last_byte)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD command frame builder testbench
// Sends display requests (directed rows first, then random ones) in bursts
// with random gaps against a stalling receiver. Every frame beat is checked
// field by field against frames worked out in the bench or typed in.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 350;
    localparam int SETTLE_BEATS = 16;
    localparam int TIMEOUT_NS   = 2_000_000;

    localparam logic [7:0] PAYLOAD_ON  = 8'h01;
    localparam logic [7:0] PAYLOAD_OFF = 8'h00;
    localparam logic [7:0] PAYLOAD_PAD = 8'h00;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        logic [1:0] ch;
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef struct {
        lcfb_pkg::t_req req;
        logic [1:0]     ch;
        logic [6:0]     val;
        bit             typed;
        logic [47:0]    frm;
    } t_row;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [1:0]  i_channel  = '0;
    logic [6:0]  i_value    = '0;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_out_channel;
    logic [7:0]  o_frame_byte;
    logic        o_last_byte;

    t_beat       beats_due[$];
    t_row        dir_rows[$];
    int          err_count  = 0;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    lcd_command_frame_builder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_channel     (i_channel),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_frame_byte  (o_frame_byte),
        .o_last_byte   (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top failed");
        $finish;
    end

    function automatic int frame_len(lcfb_pkg::t_req req);
        return (req == lcfb_pkg::REQ_ON || req == lcfb_pkg::REQ_OFF) ? 4 : 6;
    endfunction

    function automatic logic [7:0] byte_at(logic [47:0] frm, int k);
        return frm[47-8*k -: 8];
    endfunction

    // Frames are packed header first, in the top byte.
    function automatic logic [47:0] build_frame(lcfb_pkg::t_req req, logic [6:0] val);
        logic [7:0] b [6];
        logic [6:0] v;
        logic [7:0] bar;
        logic [7:0] rev;
        logic [7:0] sum;
        int         n;
        for (int k = 0; k < 6; k++) b[k] = 8'h00;
        v    = (val > lcfb_pkg::VALUE_MAX) ? lcfb_pkg::VALUE_MAX : val;
        n    = frame_len(req);
        b[0] = lcfb_pkg::FRAME_HEAD;
        case (req)
            lcfb_pkg::REQ_ON, lcfb_pkg::REQ_OFF: begin
                b[1] = lcfb_pkg::CMD_ONOFF;
                b[2] = (req == lcfb_pkg::REQ_ON) ? PAYLOAD_ON : PAYLOAD_OFF;
            end
            lcfb_pkg::REQ_DIGIT: begin
                b[1] = lcfb_pkg::CMD_DIGITS;
                b[2] = (v == lcfb_pkg::VALUE_MAX) ? lcfb_pkg::DIGIT_ONE
                                                  : lcfb_pkg::DIGIT_BLANK;
                b[3] = 8'((v / 10) % 10);
                b[4] = 8'(v % 10);
            end
            default: begin
                bar = lcfb_pkg::BAR_FULL;
                for (int k = 1; k <= lcfb_pkg::BAR_COUNT; k++) begin
                    if (val < k * lcfb_pkg::BAR_STEP) bar = bar << 1;
                end
                for (int i = 0; i < 8; i++) rev[i] = bar[7-i];
                b[1] = lcfb_pkg::CMD_SEGS;
                b[2] = lcfb_pkg::PCT_BIT | {bar[6], bar[7], 6'b0};
                b[3] = (rev >> 2) | lcfb_pkg::OUTLINE_BIT;
                b[4] = PAYLOAD_PAD;
            end
        endcase
        sum = 8'h00;
        for (int k = 1; k < n - 1; k++) sum = sum + b[k];
        b[n-1] = sum;
        return {b[0], b[1], b[2], b[3], b[4], b[5]};
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        err_count++;
    endtask

    task automatic send_request(input lcfb_pkg::t_req req, input logic [1:0] ch,
                                input logic [6:0] val, input logic [47:0] frm);
        int n;
        n = frame_len(req);
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_channel  <= ch;
        i_value    <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        for (int k = 0; k < n; k++) begin
            beats_due.push_back('{ch, byte_at(frm, k), (k == n - 1)});
        end
    endtask

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic wait_frames_done();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (beats_due.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 2));
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            default:     i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_beat seen;
        t_beat due;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = '{o_out_channel, o_frame_byte, o_last_byte};
            if (beats_due.size() == 0) begin
                report_mismatch($sformatf("beat ch=%0d byte=%h last=%b with none expected",
                                          seen.ch, seen.data, seen.last));
            end else begin
                due = beats_due.pop_front();
                if (seen.ch !== due.ch)
                    report_mismatch($sformatf("channel %0d, expected %0d", seen.ch, due.ch));
                if (seen.data !== due.data)
                    report_mismatch($sformatf("frame byte %h, expected %h",
                                              seen.data, due.data));
                if (seen.last !== due.last)
                    report_mismatch($sformatf("last flag %b, expected %b",
                                              seen.last, due.last));
            end
        end
    end

    initial begin
        t_row           row;
        lcfb_pkg::t_req req;
        logic [6:0]     val;
        logic [47:0]    frm;

        dir_rows.push_back('{lcfb_pkg::REQ_ON,    2'd0, 7'd0,   1'b1, 48'hC5_01_01_02_00_00});
        dir_rows.push_back('{lcfb_pkg::REQ_OFF,   2'd3, 7'd127, 1'b1, 48'hC5_01_00_01_00_00});
        dir_rows.push_back('{lcfb_pkg::REQ_ON,    2'd2, 7'd85,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_OFF,   2'd1, 7'd42,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_DIGIT, 2'd1, 7'd0,   1'b1, 48'hC5_02_10_00_00_12});
        dir_rows.push_back('{lcfb_pkg::REQ_DIGIT, 2'd2, 7'd100, 1'b1, 48'hC5_02_01_00_00_03});
        dir_rows.push_back('{lcfb_pkg::REQ_DIGIT, 2'd3, 7'd127, 1'b1, 48'hC5_02_01_00_00_03});
        dir_rows.push_back('{lcfb_pkg::REQ_DIGIT, 2'd0, 7'd101, 1'b1, 48'hC5_02_01_00_00_03});
        dir_rows.push_back('{lcfb_pkg::REQ_DIGIT, 2'd1, 7'd99,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_DIGIT, 2'd2, 7'd9,   1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_DIGIT, 2'd3, 7'd10,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_DIGIT, 2'd0, 7'd64,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd0, 7'd0,   1'b1, 48'hC5_03_60_40_00_A3});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd1, 7'd100, 1'b1, 48'hC5_03_E0_7F_00_62});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd2, 7'd127, 1'b1, 48'hC5_03_E0_7F_00_62});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd3, 7'd12,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd0, 7'd13,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd1, 7'd25,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd2, 7'd26,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd3, 7'd52,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd0, 7'd90,  1'b0, 48'h0});
        dir_rows.push_back('{lcfb_pkg::REQ_BAR,   2'd1, 7'd91,  1'b0, 48'h0});

        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            frm = row.typed ? row.frm : build_frame(row.req, row.val);
            send_request(row.req, row.ch, row.val, frm);
            pace_sender();
        end
        wait_frames_done();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            req = lcfb_pkg::t_req'($urandom_range(0, 3));
            val = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                              : 7'($urandom_range(0, 100));
            send_request(req, 2'($urandom_range(0, 3)), val, build_frame(req, val));
            if (i == RANDOM_ITEMS / 2) begin
                wait_frames_done();
            end else begin
                pace_sender();
            end
        end

        wait_frames_done();
        repeat (SETTLE_BEATS) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
